/* rtl/bap_pkg.sv */
// Shared types and constants for the block average pixelate filter.
`default_nettype none
package bap_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;

    localparam logic [2:0] CfgImageWidth  = 3'd0;
    localparam logic [2:0] CfgImageHeight = 3'd1;
    localparam logic [2:0] CfgBlockWidth  = 3'd2;
    localparam logic [2:0] CfgBlockHeight = 3'd3;
    localparam logic [2:0] CfgOffsetX     = 3'd4;
    localparam logic [2:0] CfgOffsetY     = 3'd5;

    typedef struct packed {
        logic       func;
        logic [7:0] in_alpha;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in_word;

    typedef struct packed {
        logic       last_pixel;
        logic [7:0] out_alpha;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_POS,
        ST_MODX,
        ST_MODY,
        ST_CHECK,
        ST_WRAP,
        ST_ACC_ADDR,
        ST_ACC_READ,
        ST_ACC_ADD,
        ST_DIV,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

/* rtl/block_average_pixelate.sv */
// Top level of the block average pixelate filter: frame store, sequencer and shared unit.
// Load word: busy in ST_LOAD, so the next word is accepted once back in ST_IDLE.
// Output word, cached block: busy in ST_POS (stepping py, the row), ST_MODX/ST_MODY (kx/ky
//   steps reducing the grid phase by block size), ST_CHECK, ST_EMIT; strobe in the next cycle.
// New block: origin wrap steps, address/read/add per bw*bh read, divide; no output stall.
// Synchronous active-low reset clears positions and cache, sets configuration defaults; no store clear.
`default_nettype none
module block_average_pixelate #(
    parameter int MAX_WIDTH  = bap_pkg::MaxWidth,
    parameter int MAX_HEIGHT = bap_pkg::MaxHeight
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire bap_pkg::t_in_word i_in_word,
    output logic                 o_strobe,
    output bap_pkg::t_out_word   o_out_word,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_index,
    input  wire [8:0]            i_cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int MW = PW + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int SW = 32;
    localparam int CW = 16;

    logic [8:0] r_cfg_w, r_cfg_h;
    logic [7:0] r_cfg_bw, r_cfg_bh;
    logic signed [8:0] r_cfg_ox, r_cfg_oy;

    bap_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_load_pos, r_emit_pos;
    logic [XW-1:0] r_px;
    logic [YW-1:0] r_py;
    logic signed [MW-1:0] r_mod;
    logic signed [13:0] r_x0s, r_y0s, r_cx0s, r_cy0s;
    logic signed [13:0] r_wx, r_wy;
    logic r_cache_valid;
    logic [31:0] r_cache_pix;
    logic [7:0] r_i, r_j;
    logic [XW-1:0] r_ax;
    logic [YW-1:0] r_ay;
    logic [AW-1:0] r_addr;
    logic [SW-1:0] r_sum [4];
    logic [SW-1:0] r_rem [4];
    logic [7:0] r_quo [4];
    logic [3:0] r_bit;
    logic [31:0] r_rd;
    logic [1:0] r_ch;
    logic r_strobe;
    bap_pkg::t_out_word r_out;
    logic [31:0] mem [DEPTH];

    logic [XW-1:0] w_w;
    logic [YW-1:0] w_h;
    logic [7:0] w_bw, w_bh;
    logic [PW-1:0] w_total;
    logic [CW-1:0] w_count;

    always_comb begin
        w_w = (r_cfg_w == 9'd0) ? XW'(1) : (32'(r_cfg_w) > MAX_WIDTH) ? XW'(MAX_WIDTH)
            : XW'(r_cfg_w);
        w_h = (r_cfg_h == 9'd0) ? YW'(1) : (32'(r_cfg_h) > MAX_HEIGHT) ? YW'(MAX_HEIGHT)
            : YW'(r_cfg_h);
        w_bw = (r_cfg_bw == 8'd0) ? 8'd1 : r_cfg_bw;
        w_bh = (r_cfg_bh == 8'd0) ? 8'd1 : r_cfg_bh;
        w_total = PW'(w_w) * PW'(w_h);
        w_count = CW'(w_bw) * CW'(w_bh);
    end

    logic [PW-1:0] w_ld, w_ep;
    assign w_ld = (r_load_pos >= w_total) ? '0 : r_load_pos;
    assign w_ep = (r_emit_pos >= w_total) ? '0 : r_emit_pos;

    logic w_acc_done_row, w_acc_done;
    assign w_acc_done_row = (r_i == w_bw - 8'd1);
    assign w_acc_done = w_acc_done_row && (r_j == w_bh - 8'd1);
    logic w_hit;
    assign w_hit = r_cache_valid && (r_x0s == r_cx0s) && (r_y0s == r_cy0s);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bap_pkg::ST_IDLE: begin
                if (start) n_state = i_in_word.func ? bap_pkg::ST_POS : bap_pkg::ST_LOAD;
            end
            bap_pkg::ST_LOAD: n_state = bap_pkg::ST_IDLE;
            bap_pkg::ST_POS: begin
                if (32'(r_mod) < 32'(w_w)) n_state = bap_pkg::ST_MODX;
            end
            bap_pkg::ST_MODX: begin
                if (r_mod >= 0 && r_mod < MW'(w_bw)) n_state = bap_pkg::ST_MODY;
            end
            bap_pkg::ST_MODY: begin
                if (r_mod >= 0 && r_mod < MW'(w_bh)) n_state = bap_pkg::ST_CHECK;
            end
            bap_pkg::ST_CHECK: n_state = w_hit ? bap_pkg::ST_EMIT : bap_pkg::ST_WRAP;
            bap_pkg::ST_WRAP: begin
                if (r_wx >= 0 && r_wy >= 0) n_state = bap_pkg::ST_ACC_ADDR;
            end
            bap_pkg::ST_ACC_ADDR: n_state = bap_pkg::ST_ACC_READ;
            bap_pkg::ST_ACC_READ: n_state = bap_pkg::ST_ACC_ADD;
            bap_pkg::ST_ACC_ADD: n_state = w_acc_done ? bap_pkg::ST_DIV : bap_pkg::ST_ACC_ADDR;
            bap_pkg::ST_DIV: begin
                if (r_bit == 4'd0 && r_ch == 2'd3) n_state = bap_pkg::ST_EMIT;
            end
            bap_pkg::ST_EMIT: n_state = bap_pkg::ST_IDLE;
            default: n_state = bap_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != bap_pkg::ST_IDLE);
        o_strobe = r_strobe;
        o_out_word = r_out;
    end

    logic [SW-1:0] w_trial;
    assign w_trial = r_rem[r_ch] - (SW'(w_count) << r_bit);

    always_ff @(posedge i_clk) begin
        if (r_state == bap_pkg::ST_IDLE && start && !i_in_word.func) begin
            mem[AW'(w_ld)] <= {i_in_word.in_alpha, i_in_word.in_blue,
                               i_in_word.in_green, i_in_word.in_red};
        end
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bap_pkg::ST_IDLE;
            r_load_pos <= '0;
            r_emit_pos <= '0;
            r_cache_valid <= 1'b0;
            r_strobe <= 1'b0;
            r_cfg_w <= 9'd256;
            r_cfg_h <= 9'd256;
            r_cfg_bw <= 8'd12;
            r_cfg_bh <= 8'd12;
            r_cfg_ox <= '0;
            r_cfg_oy <= '0;
        end else begin
            r_state <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bap_pkg::CfgImageWidth: begin r_cfg_w <= i_cfg_data; r_cache_valid <= 1'b0; end
                    bap_pkg::CfgImageHeight: begin r_cfg_h <= i_cfg_data; r_cache_valid <= 1'b0; end
                    bap_pkg::CfgBlockWidth: begin r_cfg_bw <= i_cfg_data[7:0]; r_cache_valid <= 1'b0; end
                    bap_pkg::CfgBlockHeight: begin r_cfg_bh <= i_cfg_data[7:0]; r_cache_valid <= 1'b0; end
                    bap_pkg::CfgOffsetX: begin r_cfg_ox <= $signed(i_cfg_data); r_cache_valid <= 1'b0; end
                    bap_pkg::CfgOffsetY: begin r_cfg_oy <= $signed(i_cfg_data); r_cache_valid <= 1'b0; end
                    default: ;
                endcase
            end
            case (r_state)
                bap_pkg::ST_IDLE: begin
                    if (start && !i_in_word.func) begin
                        r_load_pos <= (w_ld + PW'(1) >= w_total) ? '0 : w_ld + PW'(1);
                        r_cache_valid <= 1'b0;
                    end else if (start) begin
                        r_emit_pos <= w_ep;
                        r_mod <= $signed({1'b0, w_ep});
                        r_py <= '0;
                    end
                end
                bap_pkg::ST_POS: begin
                    if (32'(r_mod) >= 32'(w_w)) begin
                        r_mod <= r_mod - MW'(w_w);
                        r_py <= r_py + YW'(1);
                    end else begin
                        r_px <= XW'(r_mod);
                        r_mod <= r_mod - MW'(r_cfg_ox) + MW'(w_w);
                    end
                end
                bap_pkg::ST_MODX: begin
                    if (r_mod < 0) r_mod <= r_mod + MW'(w_bw);
                    else if (r_mod >= MW'(w_bw)) r_mod <= r_mod - MW'(w_bw);
                    else begin
                        r_x0s <= 14'(MW'(r_px) - r_mod);
                        r_mod <= MW'(r_py) - MW'(r_cfg_oy) + MW'(w_h);
                    end
                end
                bap_pkg::ST_MODY: begin
                    if (r_mod < 0) r_mod <= r_mod + MW'(w_bh);
                    else if (r_mod >= MW'(w_bh)) r_mod <= r_mod - MW'(w_bh);
                    else r_y0s <= 14'(MW'(r_py) - r_mod);
                end
                bap_pkg::ST_CHECK: begin
                    r_wx <= r_x0s;
                    r_wy <= r_y0s;
                    r_i <= '0;
                    r_j <= '0;
                    for (int c = 0; c < 4; c++) r_sum[c] <= '0;
                end
                bap_pkg::ST_WRAP: begin
                    // wrap block origin into the image
                    if (r_wx < 0) r_wx <= r_wx + 14'(w_w);
                    else if (r_wy < 0) r_wy <= r_wy + 14'(w_h);
                    else begin
                        r_ax <= XW'(r_wx);
                        r_ay <= YW'(r_wy);
                    end
                end
                bap_pkg::ST_ACC_ADDR: begin
                    r_addr <= AW'(AW'(r_ay) * AW'(w_w) + AW'(r_ax));
                end
                bap_pkg::ST_ACC_ADD: begin
                    for (int c = 0; c < 4; c++)
                        r_sum[c] <= r_sum[c] + SW'(r_rd[8*c +: 8]);
                    if (w_acc_done_row) begin
                        r_i <= '0;
                        r_j <= r_j + 8'd1;
                        r_ax <= XW'(r_wx);
                        r_ay <= (r_ay + YW'(1) >= w_h) ? '0 : r_ay + YW'(1);
                    end else begin
                        r_i <= r_i + 8'd1;
                        r_ax <= (r_ax + XW'(1) >= w_w) ? '0 : r_ax + XW'(1);
                    end
                    if (w_acc_done) begin
                        for (int c = 0; c < 4; c++) begin
                            r_rem[c] <= r_sum[c] + SW'(r_rd[8*c +: 8]);
                            r_quo[c] <= '0;
                        end
                        r_bit <= 4'd7;
                        r_ch <= 2'd0;
                    end
                end
                bap_pkg::ST_DIV: begin
                    // restoring division, one quotient bit per cycle; quotient fits 8 bits
                    if (!w_trial[SW-1] && (r_rem[r_ch] >= (SW'(w_count) << r_bit))) begin
                        r_rem[r_ch] <= w_trial;
                        r_quo[r_ch][r_bit[2:0]] <= 1'b1;
                    end
                    if (r_bit == 4'd0) begin
                        r_bit <= 4'd7;
                        r_ch <= r_ch + 2'd1;
                    end else r_bit <= r_bit - 4'd1;
                end
                bap_pkg::ST_EMIT: begin
                    if (!w_hit) begin
                        r_cache_pix <= {r_quo[3], r_quo[2], r_quo[1], r_quo[0]};
                        r_cx0s <= r_x0s;
                        r_cy0s <= r_y0s;
                        r_cache_valid <= 1'b1;
                    end
                    r_out.out_red <= w_hit ? r_cache_pix[7:0] : r_quo[0];
                    r_out.out_green <= w_hit ? r_cache_pix[15:8] : r_quo[1];
                    r_out.out_blue <= w_hit ? r_cache_pix[23:16] : r_quo[2];
                    r_out.out_alpha <= w_hit ? r_cache_pix[31:24] : r_quo[3];
                    r_out.last_pixel <= (r_emit_pos == w_total - PW'(1));
                    r_emit_pos <= (r_emit_pos + PW'(1) >= w_total) ? '0 : r_emit_pos + PW'(1);
                    r_strobe <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe) else $error("strobe held");
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) == bap_pkg::ST_EMIT) else $error("stray strobe");
    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && start && !busy && !i_in_word.func |=> r_state == bap_pkg::ST_LOAD)
        else $error("load word not taken");
    a_idle_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bap_pkg::ST_LOAD) |=> !r_strobe) else $error("load strobed");
`endif
endmodule
`default_nettype wire
